/* sv/trilinear_interp_with_gradient_top_macros.svh */
// Assertion macros shared by the trilinear interpolation block.
`ifndef TRILINEAR_INTERP_WITH_GRADIENT_TOP_MACROS_SVH
`define TRILINEAR_INTERP_WITH_GRADIENT_TOP_MACROS_SVH

// Same-cycle implication, checked on i_clk outside reset.
`define TIG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk outside reset.
`define TIG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/tig_pkg.sv */
// Shared types and constants of the trilinear interpolation block.
package tig_pkg;

    localparam int NSTG   = 6;   // register stages from request to result
    localparam int CFG_W  = 16;  // inverse resolution, unsigned Q8.8

    localparam logic [CFG_W-1:0] INV_RES_RST = 16'd2560;  // 10.0
    localparam logic [16:0]      ONE_Q16     = 17'h1_0000;

    typedef struct packed {
        logic signed [15:0] corner_000;
        logic signed [15:0] corner_001;
        logic signed [15:0] corner_010;
        logic signed [15:0] corner_011;
        logic signed [15:0] corner_100;
        logic signed [15:0] corner_101;
        logic signed [15:0] corner_110;
        logic signed [15:0] corner_111;
        logic        [15:0] frac_x;
        logic        [15:0] frac_y;
        logic        [15:0] frac_z;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] distance_value;
        logic signed [31:0] grad_x;
        logic signed [31:0] grad_y;
        logic signed [31:0] grad_z;
    } t_out_item;

endpackage

/* sv/tig_chan_if.sv */
// Valid/ready channel carrying one payload of a chosen type.
interface tig_chan_if #(
    parameter type t_data = logic [15:0]
) ();
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* sv/tig_datapath.sv */
// Six-stage arithmetic pipeline: lerps, gradient sums, scaling and saturation.
module tig_datapath (
    input  logic                       i_clk,
    input  logic [tig_pkg::NSTG-1:0]   i_en,
    input  tig_pkg::t_in_item          i_item,
    input  logic [tig_pkg::CFG_W-1:0]  i_inv_res,
    output tig_pkg::t_out_item         o_item
);
    import tig_pkg::*;

    localparam logic signed [49:0] RND_Q16 = 50'sh0_0000_8000;
    localparam logic signed [49:0] RND_Q32 = 50'sh0_8000_0000;

    function automatic logic [31:0] sat_q1616(input logic [33:0] v);
        logic [31:0] res;
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
            res = v[31:0];
        end else if (v[33]) begin
            res = 32'h8000_0000;
        end else begin
            res = 32'h7fff_ffff;
        end
        return res;
    endfunction

    // Stage 0: x lerps, x differences, y/z weight products
    logic signed [15:0] c_near [4];
    logic signed [15:0] c_far  [4];
    logic signed [16:0] s0_d   [4];
    logic signed [33:0] s0_xv  [4];
    logic        [16:0] s0_gy, s0_gz;
    logic        [33:0] s0_w   [4];

    logic signed [31:0] r_s0_v [4];
    logic signed [16:0] r_s0_d [4];
    logic        [32:0] r_s0_w [4];
    logic        [15:0] r_s0_fy, r_s0_fz;

    assign c_near[0] = i_item.corner_000;
    assign c_near[1] = i_item.corner_001;
    assign c_near[2] = i_item.corner_010;
    assign c_near[3] = i_item.corner_011;
    assign c_far[0]  = i_item.corner_100;
    assign c_far[1]  = i_item.corner_101;
    assign c_far[2]  = i_item.corner_110;
    assign c_far[3]  = i_item.corner_111;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            s0_d[i]  = $signed({c_far[i][15], c_far[i]}) - $signed({c_near[i][15], c_near[i]});
            s0_xv[i] = s0_d[i] * $signed({1'b0, i_item.frac_x})
                     + $signed({{2{c_near[i][15]}}, c_near[i], 16'h0000});
        end
        s0_gy   = ONE_Q16 - {1'b0, i_item.frac_y};
        s0_gz   = ONE_Q16 - {1'b0, i_item.frac_z};
        s0_w[0] = {17'h0, s0_gz} * {17'h0, s0_gy};
        s0_w[1] = {18'h0, i_item.frac_z} * {17'h0, s0_gy};
        s0_w[2] = {17'h0, s0_gz} * {18'h0, i_item.frac_y};
        s0_w[3] = {18'h0, i_item.frac_z} * {18'h0, i_item.frac_y};
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int i = 0; i < 4; i++) begin
                r_s0_v[i] <= s0_xv[i][31:0];
                r_s0_d[i] <= s0_d[i];
                r_s0_w[i] <= s0_w[i][32:0];
            end
            r_s0_fy <= i_item.frac_y;
            r_s0_fz <= i_item.frac_z;
        end
    end

    // Stage 1: y differences of the x lerps, weighted x differences
    logic signed [32:0] s1_ey [2];
    logic signed [49:0] s1_px [4];

    logic signed [31:0] r_s1_v00, r_s1_v01;
    logic signed [32:0] r_s1_ey [2];
    logic signed [49:0] r_s1_px [4];
    logic        [15:0] r_s1_fy, r_s1_fz;

    always_comb begin
        s1_ey[0] = $signed({r_s0_v[2][31], r_s0_v[2]}) - $signed({r_s0_v[0][31], r_s0_v[0]});
        s1_ey[1] = $signed({r_s0_v[3][31], r_s0_v[3]}) - $signed({r_s0_v[1][31], r_s0_v[1]});
        for (int i = 0; i < 4; i++) begin
            s1_px[i] = r_s0_d[i] * $signed({1'b0, r_s0_w[i]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_s1_v00 <= r_s0_v[0];
            r_s1_v01 <= r_s0_v[1];
            r_s1_ey  <= s1_ey;
            r_s1_px  <= s1_px;
            r_s1_fy  <= r_s0_fy;
            r_s1_fz  <= r_s0_fz;
        end
    end

    // Stage 2: y lerp products, z-weighted y differences, x gradient sum
    logic        [16:0] s2_gz;
    logic signed [49:0] s2_py [2];
    logic signed [49:0] s2_qz [2];
    logic signed [49:0] s2_sx;

    logic signed [31:0] r_s2_v00, r_s2_v01;
    logic signed [49:0] r_s2_py [2];
    logic signed [49:0] r_s2_qz [2];
    logic signed [49:0] r_s2_sx;
    logic        [15:0] r_s2_fz;

    always_comb begin
        s2_gz    = ONE_Q16 - {1'b0, r_s1_fz};
        s2_py[0] = r_s1_ey[0] * $signed({1'b0, r_s1_fy});
        s2_py[1] = r_s1_ey[1] * $signed({1'b0, r_s1_fy});
        s2_qz[0] = r_s1_ey[0] * $signed({1'b0, s2_gz});
        s2_qz[1] = r_s1_ey[1] * $signed({1'b0, r_s1_fz});
        s2_sx    = r_s1_px[0] + r_s1_px[1] + r_s1_px[2] + r_s1_px[3];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_s2_v00 <= r_s1_v00;
            r_s2_v01 <= r_s1_v01;
            r_s2_py  <= s2_py;
            r_s2_qz  <= s2_qz;
            r_s2_sx  <= s2_sx;
            r_s2_fz  <= r_s1_fz;
        end
    end

    // Stage 3: round to Q8.24 and finish the y lerps
    logic signed [49:0] s3_pr [2];
    logic signed [49:0] s3_qs;
    logic signed [49:0] s3_xs;

    logic signed [31:0] r_s3_v0, r_s3_v1;
    logic signed [32:0] r_s3_dy, r_s3_dx;
    logic        [15:0] r_s3_fz;

    always_comb begin
        s3_pr[0] = r_s2_py[0] + RND_Q16;
        s3_pr[1] = r_s2_py[1] + RND_Q16;
        s3_qs    = r_s2_qz[0] + r_s2_qz[1] + RND_Q16;
        s3_xs    = r_s2_sx + RND_Q16;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            // results are known to fit, so wrap-around adds are exact
            r_s3_v0 <= r_s2_v00 + $signed(s3_pr[0][47:16]);
            r_s3_v1 <= r_s2_v01 + $signed(s3_pr[1][47:16]);
            r_s3_dy <= $signed(s3_qs[48:16]);
            r_s3_dx <= $signed(s3_xs[48:16]);
            r_s3_fz <= r_s2_fz;
        end
    end

    // Stage 4: z lerp product and gradient scaling
    logic signed [32:0] s4_dz;
    logic signed [16:0] s4_ir;
    logic signed [49:0] s4_pz;
    logic signed [49:0] s4_g [3];

    logic signed [31:0] r_s4_v0;
    logic signed [49:0] r_s4_pz;
    logic signed [49:0] r_s4_g [3];

    always_comb begin
        s4_dz   = $signed({r_s3_v1[31], r_s3_v1}) - $signed({r_s3_v0[31], r_s3_v0});
        s4_ir   = $signed({1'b0, i_inv_res});
        s4_pz   = s4_dz * $signed({1'b0, r_s3_fz});
        s4_g[0] = r_s3_dx * s4_ir;
        s4_g[1] = r_s3_dy * s4_ir;
        s4_g[2] = s4_dz * s4_ir;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_s4_v0 <= r_s3_v0;
            r_s4_pz <= s4_pz;
            r_s4_g  <= s4_g;
        end
    end

    // Stage 5: final rounding, saturation, result register
    logic signed [49:0] s5_vs;
    logic signed [49:0] s5_gr [3];
    t_out_item          r_s5_out;

    always_comb begin
        s5_vs = $signed({{2{r_s4_v0[31]}}, r_s4_v0, 16'h0000}) + r_s4_pz + RND_Q32;
        for (int i = 0; i < 3; i++) begin
            s5_gr[i] = r_s4_g[i] + RND_Q16;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r_s5_out.distance_value <= $signed(s5_vs[47:32]);
            r_s5_out.grad_x         <= $signed(sat_q1616(s5_gr[0][49:16]));
            r_s5_out.grad_y         <= $signed(sat_q1616(s5_gr[1][49:16]));
            r_s5_out.grad_z         <= $signed(sat_q1616(s5_gr[2][49:16]));
        end
    end

    assign o_item = r_s5_out;

endmodule

/* sv/trilinear_interp_with_gradient_top.sv */
// Trilinear distance interpolation with analytic gradient: top level.
// Takes one request per clock unless a stalled output has filled the
// pipeline: the eight signed Q8.8 corner distances of a voxel cube and the
// unsigned Q0.16 fractional position inside it. Each request yields exactly
// one result through six register stages, the last being the output
// register: the interpolated distance in signed Q8.8 (round half up, never
// saturates) and the three partial derivatives in signed Q16.16, each scaled
// by the inverse voxel size and saturated to the 32-bit range. Throughput is
// one request per cycle while the output is not stalled; a stalled output only
// holds the stages behind it, and empty stages close up so input keeps
// flowing until the pipeline is full. The inverse resolution (unsigned Q8.8,
// reset value 10.0) is written through the configuration channel, which is
// always ready; write it only while no request is in flight.
`include "trilinear_interp_with_gradient_top_macros.svh"

module trilinear_interp_with_gradient_top (
    input  logic     i_clk,
    input  logic     i_rst_n,
    tig_chan_if.sink   i_in,
    tig_chan_if.source o_out,
    tig_chan_if.sink   i_cfg
);
    import tig_pkg::*;

    logic [NSTG-1:0]  r_vld, n_vld;
    logic [NSTG-1:0]  stg_en;
    logic [CFG_W-1:0] r_inv_res, n_inv_res;

    // Stage enables: a stage loads when it is empty or the stage ahead
    // moves on, so bubbles are squeezed out under a stalled output.
    always_comb begin
        stg_en[NSTG-1] = !r_vld[NSTG-1] || o_out.ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            stg_en[k] = !r_vld[k] || stg_en[k+1];
        end
    end

    // Advance valid bits alongside the data; hold them on a stall.
    always_comb begin
        n_vld = r_vld;
        if (stg_en[0]) begin
            n_vld[0] = i_in.valid;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (stg_en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    // Configuration register: take every write request at once.
    always_comb begin
        n_inv_res = r_inv_res;
        if (i_cfg.valid && i_cfg.ready) begin
            n_inv_res = i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_inv_res <= INV_RES_RST;
        end else begin
            r_vld     <= n_vld;
            r_inv_res <= n_inv_res;
        end
    end

    assign i_in.ready  = stg_en[0];
    assign o_out.valid = r_vld[NSTG-1];
    assign i_cfg.ready = 1'b1;

    tig_datapath u_datapath (
        .i_clk     (i_clk),
        .i_en      (stg_en),
        .i_item    (i_in.data),
        .i_inv_res (r_inv_res),
        .o_item    (o_out.data)
    );

    `TIG_ASSERT_NXT(a_cfg_hold, !(i_cfg.valid && i_cfg.ready), $stable(r_inv_res), "inverse resolution changed without a write")
    `TIG_ASSERT_NXT(a_in_lands, i_in.valid && i_in.ready, r_vld[0], "accepted request missing from first stage")
    `TIG_ASSERT_IMP(a_full_stall, (&r_vld) && !o_out.ready, !i_in.ready, "request taken into a full stalled pipeline")
    `TIG_ASSERT_IMP(a_out_source, $rose(r_vld[NSTG-1]), $past(r_vld[NSTG-2]), "result appeared without a request behind it")

endmodule

/* bench/trilinear_interp_with_gradient_top_tb.sv */
// Self-checking bench for the trilinear distance interpolator with gradient.
`timescale 1ns / 100ps

// Drive corner/fraction requests into the interpolator and check every result
// against a predictor in the bench. The predictor follows the block's fixed-point
// recipe exactly:
//   - x lerps kept exact in Q8.24
//   - y lerps and the z lerp rounded half up
//   - gradients built from the analytic partial derivatives
//   - gradients scaled by the inverse resolution, then saturated to Q16.16
// Directed requests cover the field extremes, rounding ties and gradient
// saturation. Random requests follow under several scale settings, with random
// gaps on the request side and random stalls on the result side.
module trilinear_interp_with_gradient_top_tb;

    import tig_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int RESET_LEN   = 12;
    localparam int CYCLE_LIMIT = 400000;
    localparam int BURST_MAX   = 13;

    // Corner patterns used by the random requests.
    typedef enum int {
        FIELD_NOISE,      // every corner independent, full range
        FIELD_SMOOTH,     // corners close to a common level, as in a real map
        FIELD_EXTREME     // corners taken from the range ends, zero and all-ones
    } t_field_kind;

    logic clk;
    logic rst_n;

    tig_chan_if #(.t_data(t_in_item))    req_ch ();
    tig_chan_if #(.t_data(t_out_item))   res_ch ();
    tig_chan_if #(.t_data(logic [15:0])) cfg_ch ();

    trilinear_interp_with_gradient_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // Bench-side copy of the inverse resolution register (unsigned Q8.8).
    logic [15:0] inv_res_shadow;
    // Results predicted for accepted requests, oldest first.
    t_out_item   voxel_results_due [$];
    t_out_item   want;

    int fail_count  = 0;
    int cycle_count = 0;
    bit gap_on      = 1'b0;   // allow idle bursts between requests
    bit stall_on    = 1'b0;   // allow result-side back-pressure bursts

    // ------------------------------------------------------------------
    // Clock, watchdog
    // ------------------------------------------------------------------
    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    // Abandon the run if it hangs: a correct run needs far fewer cycles.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Round half up: add half an LSB of the target, then floor.
    function automatic longint round_up_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    // Weighted pair: near value by (1 - f), far value by f, f in Q0.16.
    function automatic longint blend(longint near_v, longint far_v, longint f);
        return near_v * (longint'(65536) - f) + far_v * f;
    endfunction

    // Scale a Q8.24 derivative by the inverse resolution.
    // Round to Q16.16, then clamp to the 32-bit signed range.
    function automatic logic [31:0] scale_gradient(longint q824, logic [15:0] inv_res);
        longint prod;
        longint r;
        prod = q824 * longint'(inv_res);
        r    = round_up_shift(prod, 16);
        if (r > longint'(32'sh7FFF_FFFF))
            r = longint'(32'sh7FFF_FFFF);
        if (r < -longint'(32'sh7FFF_FFFF) - 1)
            r = -longint'(32'sh7FFF_FFFF) - 1;
        return r[31:0];
    endfunction

    // Interpolated distance and scaled gradient for one voxel request.
    function automatic t_out_item interpolate_voxel(t_in_item it, logic [15:0] inv_res);
        longint c000, c001, c010, c011, c100, c101, c110, c111;
        longint fx, fy, fz, gy, gz;
        longint v00, v01, v10, v11, v0, v1;
        longint dval, dx, dy, dz;
        t_out_item r;
        c000 = longint'($signed(it.corner_000));
        c001 = longint'($signed(it.corner_001));
        c010 = longint'($signed(it.corner_010));
        c011 = longint'($signed(it.corner_011));
        c100 = longint'($signed(it.corner_100));
        c101 = longint'($signed(it.corner_101));
        c110 = longint'($signed(it.corner_110));
        c111 = longint'($signed(it.corner_111));
        fx   = longint'(it.frac_x);
        fy   = longint'(it.frac_y);
        fz   = longint'(it.frac_z);
        gy   = longint'(65536) - fy;
        gz   = longint'(65536) - fz;
        // x lerps, exact in Q8.24
        v00  = blend(c000, c100, fx);
        v01  = blend(c001, c101, fx);
        v10  = blend(c010, c110, fx);
        v11  = blend(c011, c111, fx);
        // y lerps back to Q8.24, z lerp down to Q8.8
        v0   = round_up_shift(blend(v00, v10, fy), 16);
        v1   = round_up_shift(blend(v01, v11, fy), 16);
        dval = round_up_shift(blend(v0, v1, fz), 32);
        // partial derivatives in Q8.24
        dz   = v1 - v0;
        dy   = round_up_shift(gz * (v10 - v00) + fz * (v11 - v01), 16);
        dx   = round_up_shift(gz * gy * (c100 - c000) + gz * fy * (c110 - c010)
                            + fz * gy * (c101 - c001) + fz * fy * (c111 - c011), 16);
        r.distance_value = dval[15:0];
        r.grad_x         = scale_gradient(dx, inv_res);
        r.grad_y         = scale_gradient(dy, inv_res);
        r.grad_z         = scale_gradient(dz, inv_res);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result side: back-pressure and checking
    // ------------------------------------------------------------------

    // Hold ready low in random bursts while stalls are allowed, else keep it high.
    initial begin
        int unsigned hold;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (stall_on && $urandom_range(0, 7) == 0) begin
                hold = $urandom_range(1, BURST_MAX);
                res_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
        end
    end

    task automatic compare_field(string name, longint want_v, longint got_v);
        if (want_v != got_v) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d",
                     $time, name, want_v, got_v);
        end
    endtask

    // Match every accepted result against the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && res_ch.valid && res_ch.ready) begin
            if (voxel_results_due.size() == 0) begin
                fail_count++;
                $display("%0t: result with none expected, expected nothing, got %h",
                         $time, res_ch.data);
            end else begin
                want = voxel_results_due.pop_front();
                compare_field("distance_value", longint'($signed(want.distance_value)),
                              longint'($signed(res_ch.data.distance_value)));
                compare_field("grad_x", longint'($signed(want.grad_x)),
                              longint'($signed(res_ch.data.grad_x)));
                compare_field("grad_y", longint'($signed(want.grad_y)),
                              longint'($signed(res_ch.data.grad_y)));
                compare_field("grad_z", longint'($signed(want.grad_z)),
                              longint'($signed(res_ch.data.grad_z)));
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Present one request, wait for its handshake, then record the prediction.
    // Call on a rising edge. Valid stays high into the next request unless a gap is drawn.
    task automatic send_request(t_in_item it);
        req_ch.valid <= 1'b1;
        req_ch.data  <= it;
        do @(posedge clk); while (!req_ch.ready);
        voxel_results_due.push_back(interpolate_voxel(it, inv_res_shadow));
        if (gap_on && $urandom_range(0, 5) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, BURST_MAX)) @(posedge clk);
        end
    endtask

    // Stop sending and wait until every predicted result has come back.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (voxel_results_due.size() != 0) @(posedge clk);
    endtask

    // Write the inverse resolution once the pipeline is empty.
    task automatic cfg_write(logic [15:0] value);
        drain_results();
        repeat (NSTG + 2) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid   <= 1'b0;
        inv_res_shadow  = value;
    endtask

    // Build a request from plain integers: corners as signed Q8.8 and fractions as Q0.16.
    function automatic t_in_item cube(int c000, int c001, int c010, int c011,
                                      int c100, int c101, int c110, int c111,
                                      int fx, int fy, int fz);
        t_in_item it;
        it.corner_000 = 16'(c000);
        it.corner_001 = 16'(c001);
        it.corner_010 = 16'(c010);
        it.corner_011 = 16'(c011);
        it.corner_100 = 16'(c100);
        it.corner_101 = 16'(c101);
        it.corner_110 = 16'(c110);
        it.corner_111 = 16'(c111);
        it.frac_x     = 16'(fx);
        it.frac_y     = 16'(fy);
        it.frac_z     = 16'(fz);
        return it;
    endfunction

    function automatic logic [15:0] pick_corner(t_field_kind kind, int level);
        int v;
        case (kind)
            FIELD_NOISE: begin
                return 16'($urandom);
            end
            FIELD_SMOOTH: begin
                v = level + int'($urandom_range(0, 4000)) - 2000;
                if (v > 32767)
                    v = 32767;
                if (v < -32768)
                    v = -32768;
                return 16'(v);
            end
            default: begin
                case ($urandom_range(0, 3))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
        endcase
    endfunction

    // Fractions: mostly uniform, with zero, the top code and one half mixed in.
    function automatic logic [15:0] pick_frac();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in_item random_request();
        t_field_kind kind;
        int          level;
        int unsigned pick;
        t_in_item    it;
        pick  = $urandom_range(0, 9);
        kind  = (pick < 4) ? FIELD_NOISE : (pick < 8) ? FIELD_SMOOTH : FIELD_EXTREME;
        level = int'($urandom_range(0, 60000)) - 30000;
        it.corner_000 = pick_corner(kind, level);
        it.corner_001 = pick_corner(kind, level);
        it.corner_010 = pick_corner(kind, level);
        it.corner_011 = pick_corner(kind, level);
        it.corner_100 = pick_corner(kind, level);
        it.corner_101 = pick_corner(kind, level);
        it.corner_110 = pick_corner(kind, level);
        it.corner_111 = pick_corner(kind, level);
        it.frac_x     = pick_frac();
        it.frac_y     = pick_frac();
        it.frac_z     = pick_frac();
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Directed requests at the reset scale of 10.0: field extremes, steep faces
    // along each axis, and rounding ties of either sign.
    task automatic test_reset_scale();
        send_request(cube(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(cube(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                          65535, 65535, 65535));
        send_request(cube(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                          32768, 32768, 32768));
        // steepest rise along x, sampled on the near faces
        send_request(cube(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767,
                          0, 0, 0));
        // steepest fall along y
        send_request(cube(32767, 32767, -32768, -32768, 32767, 32767, -32768, -32768,
                          65535, 32768, 1));
        // steepest rise along z
        send_request(cube(-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767,
                          1, 65535, 32768));
        // only the far corner set, fractions at their top code
        send_request(cube(0, 0, 0, 0, 0, 0, 0, 32767, 65535, 65535, 65535));
        // half-LSB ties: positive rounds up, negative rounds towards zero
        send_request(cube(1, 0, 0, 0, 0, 0, 0, 0, 32768, 0, 0));
        send_request(cube(-1, 0, 0, 0, 0, 0, 0, 0, 32768, 0, 0));
        // checkerboard of range ends
        send_request(cube(32767, -32768, -32768, 32767, -32768, 32767, 32767, -32768,
                          12345, 54321, 40000));
    endtask

    // Scale extremes: the largest scale drives the steep gradients into saturation,
    // a zero scale flattens all of them.
    task automatic test_scale_extremes();
        cfg_write(16'hFFFF);
        send_request(cube(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767,
                          100, 200, 300));
        send_request(cube(32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768,
                          65535, 0, 65535));
        send_request(cube(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767,
                          32768, 32768, 0));
        send_request(cube(32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768,
                          0, 65535, 65535));
        send_request(cube(100, -200, 300, -400, 500, -600, 700, -800, 4096, 8192, 16384));
        cfg_write(16'h0000);
        send_request(cube(32767, -32768, -32768, 32767, -32768, 32767, 32767, -32768,
                          30000, 20000, 10000));
        send_request(cube(-32768, 32767, -32768, 32767, 32767, -32768, 32767, -32768,
                          65535, 65535, 0));
    endtask

    // Random requests under one scale. Idling comes and goes in stretches, and
    // halfway through the sender holds off until the pipeline has emptied.
    task automatic test_random_stream(logic [15:0] scale, int count, bit idling);
        cfg_write(scale);
        for (int i = 0; i < count; i++) begin
            gap_on   = idling && ((i / 64) % 3 != 2);
            stall_on = idling && ((i / 64) % 3 != 1);
            if (i == count / 2)
                drain_results();
            send_request(random_request());
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        req_ch.valid   <= 1'b0;
        req_ch.data    <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.data    <= '0;
        rst_n          <= 1'b0;
        inv_res_shadow  = INV_RES_RST;

        repeat (RESET_LEN) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_scale();
        test_scale_extremes();
        test_random_stream(16'($urandom_range(0, 65535)), 320, 1'b1);
        test_random_stream(16'd256, 320, 1'b1);
        test_random_stream(16'hFFFF, 320, 1'b1);
        test_random_stream(16'h0000, 200, 1'b1);
        test_random_stream(16'($urandom_range(1, 4096)), 440, 1'b1);
        // closing stretch: both sides flat out
        test_random_stream(INV_RES_RST, 150, 1'b0);

        // let any stray result surface before the verdict
        drain_results();
        repeat (NSTG + 4) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* trilinear_interp_with_gradient_top.f */
+incdir+sv
sv/tig_pkg.sv
sv/tig_chan_if.sv
sv/tig_datapath.sv
sv/trilinear_interp_with_gradient_top.sv
bench/trilinear_interp_with_gradient_top_tb.sv
